[rtl/core/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// shared constants and operation codes of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_SQRT = 3'd4
    } op_t;

endpackage

[rtl/core/cau_req_if.sv]
// ----------------------------------------------------------------------------
// cau_req_if
// request channel: operation code and two complex operands
// ----------------------------------------------------------------------------
interface cau_req_if #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS
) ();
    logic                        valid;
    logic                        ready;
    logic [2:0]                  req_type;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;

    modport source (output valid, output req_type, output a_re, output a_im,
                    output b_re, output b_im, input ready);
    modport sink   (input valid, input req_type, input a_re, input a_im,
                    input b_re, input b_im, output ready);
endinterface

[rtl/core/cau_rsp_if.sv]
// ----------------------------------------------------------------------------
// cau_rsp_if
// response channel: complex result and status flags
// ----------------------------------------------------------------------------
interface cau_rsp_if #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS
) ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    logic                        div_zero;
    logic                        overflow;

    modport source (output valid, output res_re, output res_im, output div_zero,
                    output overflow, input ready);
    modport sink   (input valid, input res_re, input res_im, input div_zero,
                    input overflow, output ready);
endinterface

[rtl/core/cau_div_pipe.sv]
// ----------------------------------------------------------------------------
// cau_div_pipe
// pipelined restoring divider, quotient (num << FRAC_BITS) / den, one bit
// per stage, with a flag for quotients that do not fit WORD_BITS
// ----------------------------------------------------------------------------
module cau_div_pipe #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [2*WORD_BITS-1:0]   num,
    input  logic [2*WORD_BITS-1:0]   den,
    output logic [WORD_BITS-1:0]     quo,
    output logic                     big
);
    localparam int W  = WORD_BITS;
    localparam int DW = 2 * WORD_BITS;

    logic [DW-1:0] rem_reg  [0:W-1];
    logic [W-1:0]  low_reg  [0:W-1];
    logic [DW-1:0] d_reg    [0:W-1];
    logic [W-1:0]  q_reg    [0:W];
    logic          big_reg  [0:W];

    logic [DW-1:0] hi;
    logic [DW-1:0] nsh;
    logic [DW:0]   t        [1:W];
    logic          ge       [1:W];
    logic [DW-1:0] rem_next [1:W-1];

    assign hi  = num >> (W - FRAC_BITS);
    assign nsh = num << FRAC_BITS;

    always_comb
    begin
        for (int k = 1; k <= W; k++)
        begin
            t[k]  = {rem_reg[k-1], low_reg[k-1][W-1]};
            ge[k] = t[k] >= {1'b0, d_reg[k-1]};
        end
        for (int k = 1; k < W; k++)
        begin
            rem_next[k] = ge[k] ? DW'(t[k] - {1'b0, d_reg[k-1]}) : t[k][DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= hi;
            low_reg[0] <= nsh[W-1:0];
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            big_reg[0] <= hi >= den;
            for (int k = 1; k < W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_reg[k-1] << 1;
                d_reg[k]   <= d_reg[k-1];
            end
            for (int k = 1; k <= W; k++)
            begin
                q_reg[k]   <= {q_reg[k-1][W-2:0], ge[k]};
                big_reg[k] <= big_reg[k-1];
            end
        end
    end

    assign quo = q_reg[W];
    assign big = big_reg[W];

endmodule

[rtl/core/cau_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// cau_sqrt_pipe
// pipelined integer square root, floor(sqrt(x)), one root bit per stage
// ----------------------------------------------------------------------------
module cau_sqrt_pipe #(
    parameter int OUT_W = cau_pkg::WORD_BITS
) (
    input  logic               clk,
    input  logic               en,
    input  logic [2*OUT_W-1:0] x,
    output logic [OUT_W-1:0]   root
);
    localparam int XW = 2 * OUT_W;
    localparam int RW = OUT_W + 2;

    logic [XW-1:0]    x_reg    [0:OUT_W-1];
    logic [RW-1:0]    rem_reg  [0:OUT_W-1];
    logic [OUT_W-1:0] root_reg [0:OUT_W];

    logic [RW+1:0]    t        [1:OUT_W];
    logic [RW+1:0]    trial    [1:OUT_W];
    logic             ge       [1:OUT_W];
    logic [RW-1:0]    rem_next [1:OUT_W-1];

    always_comb
    begin
        for (int k = 1; k <= OUT_W; k++)
        begin
            t[k]     = {rem_reg[k-1], x_reg[k-1][XW-1 -: 2]};
            trial[k] = {2'b00, root_reg[k-1], 2'b01};
            ge[k]    = t[k] >= trial[k];
        end
        for (int k = 1; k < OUT_W; k++)
        begin
            rem_next[k] = ge[k] ? RW'(t[k] - trial[k]) : t[k][RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            for (int k = 1; k < OUT_W; k++)
            begin
                x_reg[k]   <= x_reg[k-1] << 2;
                rem_reg[k] <= rem_next[k];
            end
            for (int k = 1; k <= OUT_W; k++)
            begin
                root_reg[k] <= {root_reg[k-1][OUT_W-2:0], ge[k]};
            end
        end
    end

    assign root = root_reg[OUT_W];

endmodule

[rtl/core/complex_arith_unit_top.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// complex add, subtract, multiply, divide and square root in signed fixed
// point, fully pipelined with saturating results
//
//   channel   dir   contents
//   req       in    req_type, a_re, a_im, b_re, b_im
//   rsp       out   res_re, res_im, div_zero, overflow
//
// one request enters per cycle unless the pipeline holds; the divider and
// square root lanes are each WORD_BITS+1 stages, and two lanes are placed
// one after the other for the square root
// the whole pipeline holds while a response waits and rsp.ready is low
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module complex_arith_unit_top #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    cau_req_if.sink   req,
    cau_rsp_if.source rsp
);
    localparam int W   = WORD_BITS;
    localparam int DW  = 2 * WORD_BITS;
    localparam int LAT = WORD_BITS + 1;
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};

    typedef struct packed {
        logic         neg;
        logic         big;
        logic [W-1:0] mag;
    } comp_t;

    typedef struct packed {
        cau_pkg::op_t op;
        logic [W-1:0] ar;
        logic         ai_neg;
        comp_t        pre_re;
        comp_t        pre_im;
        logic         nre_neg;
        logic         nim_neg;
        logic         dz;
    } side_a_t;

    typedef struct packed {
        cau_pkg::op_t op;
        logic         ai_neg;
        comp_t        re;
        comp_t        im;
        logic         dz;
    } side_b_t;

    function automatic logic [W:0] sat_comp(comp_t c);
        logic [W:0] r;
        if (c.neg)
        begin
            if (c.big || c.mag > HALF)
                r = {1'b1, HALF};
            else
                r = {1'b0, (~c.mag + 1'b1)};
        end
        else
        begin
            if (c.big || c.mag > MAXP)
                r = {1'b1, MAXP};
            else
                r = {1'b0, c.mag};
        end
        return r;
    endfunction

    logic en;

    // stage 1: products and sums
    logic                 v1_reg;
    cau_pkg::op_t         op_in;
    cau_pkg::op_t         op1_reg;
    logic [W-1:0]         ar1_reg;
    logic                 ai_neg1_reg;
    logic signed [W:0]    as_re1_reg, as_im1_reg;
    logic signed [DW-1:0] rr1_reg, ii1_reg, ri1_reg, ir1_reg, sq0_1_reg, sq1_1_reg;
    logic signed [W-1:0]  sx_re, sx_im;

    // stage 2: combined numerators and squared magnitude
    logic                 v2_reg;
    cau_pkg::op_t         op2_reg;
    logic [W-1:0]         ar2_reg;
    logic                 ai_neg2_reg;
    comp_t                as_re2_reg, as_im2_reg, as_re2_next, as_im2_next;
    logic signed [DW:0]   num_re2_reg, num_im2_reg, num_re2_next, num_im2_next;
    logic [DW-1:0]        d2_reg;
    logic [W:0]           as_mag_re, as_mag_im;

    // stage 3: magnitudes for the lanes
    logic                 v3_reg;
    side_a_t              s3_reg, s3_next;
    logic [DW-1:0]        mag_re3_reg, mag_im3_reg, d3_reg;
    logic [DW:0]          nmag_re, nmag_im;
    logic [DW-1:0]        msh_re, msh_im;
    comp_t                mul_re, mul_im;

    // lane section a: divider and first root
    logic                 va_reg     [0:LAT-1];
    side_a_t              side_a_reg [0:LAT-1];
    logic [W-1:0]         q_re, q_im, r1;
    logic                 big_re, big_im;

    // lane section b: second roots
    logic                 vb_reg     [0:LAT-1];
    side_b_t              side_b_reg [0:LAT-1];
    side_b_t              side_b_next;
    logic signed [W+1:0]  s_re, s_im;
    logic [DW-1:0]        x_re, x_im;
    logic [W-1:0]         root_re, root_im;

    // output stage
    logic                 vout_reg;
    logic [W-1:0]         res_re_reg, res_im_reg;
    logic                 div_zero_reg, overflow_reg;
    comp_t                fin_re, fin_im;
    logic [W:0]           sat_re, sat_im;

    assign en        = !vout_reg || rsp.ready;
    assign req.ready = en;

    assign op_in = cau_pkg::op_t'(req.req_type);
    assign sx_re = (op_in == cau_pkg::OP_SQRT) ? req.a_re : req.b_re;
    assign sx_im = (op_in == cau_pkg::OP_SQRT) ? req.a_im : req.b_im;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg     <= op_in;
            ar1_reg     <= req.a_re;
            ai_neg1_reg <= req.a_im[W-1];
            if (op_in == cau_pkg::OP_SUB)
            begin
                as_re1_reg <= req.a_re - req.b_re;
                as_im1_reg <= req.a_im - req.b_im;
            end
            else
            begin
                as_re1_reg <= req.a_re + req.b_re;
                as_im1_reg <= req.a_im + req.b_im;
            end
            rr1_reg   <= req.a_re * req.b_re;
            ii1_reg   <= req.a_im * req.b_im;
            ri1_reg   <= req.a_re * req.b_im;
            ir1_reg   <= req.a_im * req.b_re;
            sq0_1_reg <= sx_re * sx_re;
            sq1_1_reg <= sx_im * sx_im;
        end
    end

    always_comb
    begin
        as_mag_re = as_re1_reg[W] ? (W+1)'(-as_re1_reg) : as_re1_reg;
        as_mag_im = as_im1_reg[W] ? (W+1)'(-as_im1_reg) : as_im1_reg;
        as_re2_next = '{neg: as_re1_reg[W], big: as_mag_re[W], mag: as_mag_re[W-1:0]};
        as_im2_next = '{neg: as_im1_reg[W], big: as_mag_im[W], mag: as_mag_im[W-1:0]};
        if (op1_reg == cau_pkg::OP_MUL)
        begin
            num_re2_next = rr1_reg - ii1_reg;
            num_im2_next = ri1_reg + ir1_reg;
        end
        else
        begin
            num_re2_next = rr1_reg + ii1_reg;
            num_im2_next = ir1_reg - ri1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg     <= op1_reg;
            ar2_reg     <= ar1_reg;
            ai_neg2_reg <= ai_neg1_reg;
            as_re2_reg  <= as_re2_next;
            as_im2_reg  <= as_im2_next;
            num_re2_reg <= num_re2_next;
            num_im2_reg <= num_im2_next;
            d2_reg      <= $unsigned(sq0_1_reg) + $unsigned(sq1_1_reg);
        end
    end

    always_comb
    begin
        nmag_re = num_re2_reg[DW] ? (DW+1)'(-num_re2_reg) : num_re2_reg;
        nmag_im = num_im2_reg[DW] ? (DW+1)'(-num_im2_reg) : num_im2_reg;
        msh_re  = nmag_re[DW-1:0] >> FRAC_BITS;
        msh_im  = nmag_im[DW-1:0] >> FRAC_BITS;
        mul_re  = '{neg: num_re2_reg[DW], big: |msh_re[DW-1:W], mag: msh_re[W-1:0]};
        mul_im  = '{neg: num_im2_reg[DW], big: |msh_im[DW-1:W], mag: msh_im[W-1:0]};

        s3_next         = '0;
        s3_next.op      = op2_reg;
        s3_next.ar      = ar2_reg;
        s3_next.ai_neg  = ai_neg2_reg;
        s3_next.nre_neg = num_re2_reg[DW];
        s3_next.nim_neg = num_im2_reg[DW];
        s3_next.dz      = (op2_reg == cau_pkg::OP_DIV) && (d2_reg == '0);
        unique case (op2_reg) inside
            cau_pkg::OP_ADD, cau_pkg::OP_SUB:
            begin
                s3_next.pre_re = as_re2_reg;
                s3_next.pre_im = as_im2_reg;
            end
            cau_pkg::OP_MUL:
            begin
                s3_next.pre_re = mul_re;
                s3_next.pre_im = mul_im;
            end
            default:
            begin
                s3_next.pre_re = '0;
                s3_next.pre_im = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg      <= s3_next;
            mag_re3_reg <= nmag_re[DW-1:0];
            mag_im3_reg <= nmag_im[DW-1:0];
            d3_reg      <= d2_reg;
        end
    end

    cau_div_pipe #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div_re (
        .clk (clk),
        .en  (en),
        .num (mag_re3_reg),
        .den (d3_reg),
        .quo (q_re),
        .big (big_re)
    );

    cau_div_pipe #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div_im (
        .clk (clk),
        .en  (en),
        .num (mag_im3_reg),
        .den (d3_reg),
        .quo (q_im),
        .big (big_im)
    );

    cau_sqrt_pipe #(.OUT_W(W)) u_sqrt_mag (
        .clk  (clk),
        .en   (en),
        .x    (d3_reg),
        .root (r1)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_a_reg[0] <= s3_reg;
            for (int k = 1; k < LAT; k++)
            begin
                side_a_reg[k] <= side_a_reg[k-1];
            end
        end
    end

    always_comb
    begin
        s_re = $signed({2'b00, r1}) + $signed({{2{side_a_reg[LAT-1].ar[W-1]}},
                                                side_a_reg[LAT-1].ar});
        s_im = $signed({2'b00, r1}) - $signed({{2{side_a_reg[LAT-1].ar[W-1]}},
                                                side_a_reg[LAT-1].ar});
        x_re = {{(W-1){1'b0}}, s_re[W:0]} << (FRAC_BITS - 1);
        x_im = {{(W-1){1'b0}}, s_im[W:0]} << (FRAC_BITS - 1);

        side_b_next.op     = side_a_reg[LAT-1].op;
        side_b_next.ai_neg = side_a_reg[LAT-1].ai_neg;
        side_b_next.dz     = side_a_reg[LAT-1].dz;
        if (side_a_reg[LAT-1].op == cau_pkg::OP_DIV)
        begin
            if (side_a_reg[LAT-1].dz)
            begin
                side_b_next.re = '0;
                side_b_next.im = '0;
            end
            else
            begin
                side_b_next.re = '{neg: side_a_reg[LAT-1].nre_neg, big: big_re, mag: q_re};
                side_b_next.im = '{neg: side_a_reg[LAT-1].nim_neg, big: big_im, mag: q_im};
            end
        end
        else
        begin
            side_b_next.re = side_a_reg[LAT-1].pre_re;
            side_b_next.im = side_a_reg[LAT-1].pre_im;
        end
    end

    cau_sqrt_pipe #(.OUT_W(W)) u_sqrt_re (
        .clk  (clk),
        .en   (en),
        .x    (x_re),
        .root (root_re)
    );

    cau_sqrt_pipe #(.OUT_W(W)) u_sqrt_im (
        .clk  (clk),
        .en   (en),
        .x    (x_im),
        .root (root_im)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_b_reg[0] <= side_b_next;
            for (int k = 1; k < LAT; k++)
            begin
                side_b_reg[k] <= side_b_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (side_b_reg[LAT-1].op == cau_pkg::OP_SQRT)
        begin
            fin_re = '{neg: 1'b0, big: 1'b0, mag: root_re};
            fin_im = '{neg: side_b_reg[LAT-1].ai_neg, big: 1'b0, mag: root_im};
        end
        else
        begin
            fin_re = side_b_reg[LAT-1].re;
            fin_im = side_b_reg[LAT-1].im;
        end
        sat_re = sat_comp(fin_re);
        sat_im = sat_comp(fin_im);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg   <= sat_re[W-1:0];
            res_im_reg   <= sat_im[W-1:0];
            div_zero_reg <= side_b_reg[LAT-1].dz;
            overflow_reg <= sat_re[W] | sat_im[W];
        end
    end

    // valid bits travel with the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
            for (int k = 0; k < LAT; k++)
            begin
                va_reg[k] <= 1'b0;
                vb_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= req.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            va_reg[0] <= v3_reg;
            vb_reg[0] <= va_reg[LAT-1];
            for (int k = 1; k < LAT; k++)
            begin
                va_reg[k] <= va_reg[k-1];
                vb_reg[k] <= vb_reg[k-1];
            end
            vout_reg <= vb_reg[LAT-1];
        end
    end

    assign rsp.valid    = vout_reg;
    assign rsp.res_re   = res_re_reg;
    assign rsp.res_im   = res_im_reg;
    assign rsp.div_zero = div_zero_reg;
    assign rsp.overflow = overflow_reg;

endmodule

[dv/complex_arith_unit_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arith_unit_top_tb
// checks every operation of the complex arithmetic unit against a bit-exact
// fixed point predictor, with bursty requests, random response stalls, a long
// response hold-off that fills the pipeline, and a full drain mid-run
// ----------------------------------------------------------------------------
module complex_arith_unit_top_tb;

    localparam int          PIPE_CYCLES = 2 * cau_pkg::WORD_BITS + 6;
    localparam logic [2:0]  OP_RSVD5    = 3'd5;
    localparam logic [2:0]  OP_RSVD6    = 3'd6;
    localparam logic [2:0]  OP_RSVD7    = 3'd7;

    typedef logic signed [cau_pkg::WORD_BITS-1:0] word_t;
    typedef logic signed [129:0]                  wide_t;

    typedef struct packed {
        word_t re;
        word_t im;
        logic  div_zero;
        logic  overflow;
    } cplx_result_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   hold_cycles;
    int   stretch_left;
    int   stall_pct;

    cplx_result_t expected_results[$];

    cau_req_if req_if ();
    cau_rsp_if rsp_if ();

    complex_arith_unit_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [127:0] int_sqrt(input logic [127:0] x);
        logic [127:0] res;
        logic [127:0] bitv;
        logic [127:0] t;
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            t   = res + bitv;
            res = res >> 1;
            if (x >= t)
            begin
                x   = x - t;
                res = res + bitv;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic wide_t trunc_frac(input wide_t v);
        wide_t mag;
        mag = (v < 0) ? -v : v;
        mag = mag >>> cau_pkg::FRAC_BITS;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic wide_t div_frac(input wide_t v, input logic [127:0] den);
        logic [127:0] mag;
        wide_t        q;
        mag = 128'((v < 0) ? -v : v);
        mag = (mag << cau_pkg::FRAC_BITS) / den;
        q   = $signed({2'b00, mag});
        return (v < 0) ? -q : q;
    endfunction

    function automatic word_t clamp_word(input wide_t v, inout logic hit);
        wide_t hi;
        wide_t lo;
        hi = 1;
        hi = (hi <<< (cau_pkg::WORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            hit = 1'b1;
            return word_t'(hi);
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return word_t'(lo);
        end
        return word_t'(v);
    endfunction

    function automatic cplx_result_t compute_result(input logic [2:0] op,
                                                    input word_t a_re, input word_t a_im,
                                                    input word_t b_re, input word_t b_im);
        wide_t        ar, ai, br, bi, re, im;
        logic [127:0] den;
        logic [127:0] r;
        cplx_result_t res;
        res = '0;
        re  = 0;
        im  = 0;
        ar  = a_re;
        ai  = a_im;
        br  = b_re;
        bi  = b_im;
        case (op)
            cau_pkg::OP_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            cau_pkg::OP_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            cau_pkg::OP_MUL:
            begin
                re = trunc_frac(ar * br - ai * bi);
                im = trunc_frac(ar * bi + ai * br);
            end
            cau_pkg::OP_DIV:
            begin
                den = 128'(br * br + bi * bi);
                if (den == 0)
                    res.div_zero = 1'b1;
                else
                begin
                    re = div_frac(ar * br + ai * bi, den);
                    im = div_frac(ai * br - ar * bi, den);
                end
            end
            cau_pkg::OP_SQRT:
            begin
                r  = int_sqrt(128'(ar * ar + ai * ai));
                re = $signed({2'b00,
                              int_sqrt(128'((r + ar) << (cau_pkg::FRAC_BITS - 1)))});
                im = $signed({2'b00,
                              int_sqrt(128'((r - ar) << (cau_pkg::FRAC_BITS - 1)))});
                if (ai < 0)
                    im = -im;
            end
            default:
            begin
            end
        endcase
        res.re = clamp_word(re, res.overflow);
        res.im = clamp_word(im, res.overflow);
        return res;
    endfunction

    function automatic word_t rand_operand();
        case ($urandom_range(0, 7))
            0:       return word_t'(32'h7fff_ffff);
            1:       return word_t'(32'h8000_0000);
            2:       return '0;
            3:       return word_t'($signed($urandom_range(0, 8 << cau_pkg::FRAC_BITS)) -
                                    $signed(4 << cau_pkg::FRAC_BITS));
            4:       return word_t'($signed($urandom_range(0, 64)) - 32);
            default: return word_t'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send_request(input logic [2:0] op, input word_t a_re, input word_t a_im,
                                input word_t b_re, input word_t b_im);
        @(negedge clk);
        req_if.valid    <= 1'b1;
        req_if.req_type <= op;
        req_if.a_re     <= a_re;
        req_if.a_im     <= a_im;
        req_if.b_re     <= b_re;
        req_if.b_im     <= b_im;
        do
            @(posedge clk);
        while (!req_if.ready);
        expected_results.push_back(compute_result(op, a_re, a_im, b_re, b_im));
    endtask

    task automatic idle_request(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_random();
        logic [2:0] op;
        word_t      b_re;
        word_t      b_im;
        op   = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
        b_re = rand_operand();
        b_im = rand_operand();
        if (op == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0)
        begin
            b_re = '0;
            b_im = '0;
        end
        send_request(op, rand_operand(), rand_operand(), b_re, b_im);
    endtask

    task automatic wait_drain();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        word_t wmax;
        word_t wmin;
        word_t one;
        wmax = word_t'(32'h7fff_ffff);
        wmin = word_t'(32'h8000_0000);
        one  = word_t'(1 << cau_pkg::FRAC_BITS);
        send_request(cau_pkg::OP_ADD, wmax, wmin, wmax, wmin);
        send_request(cau_pkg::OP_ADD, wmin, wmax, -one, one);
        send_request(cau_pkg::OP_SUB, wmin, wmax, one, -one);
        send_request(cau_pkg::OP_SUB, wmax, '0, wmin, '0);
        send_request(cau_pkg::OP_MUL, wmax, wmax, wmax, wmin);
        send_request(cau_pkg::OP_MUL, wmin, wmin, wmin, wmin);
        send_request(cau_pkg::OP_MUL, one, one, -one, one);
        send_request(cau_pkg::OP_MUL, 32'sd3, -32'sd5, 32'sd7, 32'sd1);
        send_request(cau_pkg::OP_DIV, one, one, '0, '0);
        send_request(cau_pkg::OP_DIV, wmax, wmin, 32'sd1, '0);
        send_request(cau_pkg::OP_DIV, one, -one, one, one);
        send_request(cau_pkg::OP_DIV, wmin, wmax, wmin, wmin);
        send_request(cau_pkg::OP_DIV, -32'sd7, 32'sd3, '0, 32'sd2);
        send_request(cau_pkg::OP_SQRT, -(one * 4), '0, wmax, wmax);
        send_request(cau_pkg::OP_SQRT, one * 4, -one, '0, '0);
        send_request(cau_pkg::OP_SQRT, '0, '0, '0, '0);
        send_request(cau_pkg::OP_SQRT, wmin, wmin, '0, '0);
        send_request(cau_pkg::OP_SQRT, wmax, wmax, '0, '0);
        send_request(cau_pkg::OP_SQRT, -one, -32'sd1, '0, '0);
        send_request(OP_RSVD5, wmax, wmin, wmax, wmin);
        send_request(OP_RSVD6, one, one, one, one);
        send_request(OP_RSVD7, wmin, wmax, wmin, wmax);
        idle_request(1);
    endtask

    task automatic test_random_bursts(input int n_items);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                send_random();
                sent++;
            end
            idle_request($urandom_range(1, 8));
            if (sent >= n_items / 2 && sent - burst < n_items / 2)
                wait_drain();
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (200)
            send_random();
        idle_request(1);
    endtask

    initial
    begin
        hold_cycles     = 0;
        stretch_left    = 0;
        stall_pct       = 0;
        rsp_if.ready    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(5, 60);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                stretch_left--;
                rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cplx_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected response", 0, 0);
            else
            begin
                want = expected_results.pop_front();
                if (rsp_if.res_re !== want.re)
                    report_mismatch("res_re", rsp_if.res_re, want.re);
                if (rsp_if.res_im !== want.im)
                    report_mismatch("res_im", rsp_if.res_im, want.im);
                if (rsp_if.div_zero !== want.div_zero)
                    report_mismatch("div_zero", rsp_if.div_zero, want.div_zero);
                if (rsp_if.overflow !== want.overflow)
                    report_mismatch("overflow", rsp_if.overflow, want.overflow);
            end
        end
    end

    initial
    begin
        errors          = 0;
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = '0;
        req_if.a_re     = '0;
        req_if.a_im     = '0;
        req_if.b_re     = '0;
        req_if.b_im     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_bursts(800);
        test_backpressure();
        test_random_bursts(830);

        wait_drain();
        repeat (PIPE_CYCLES + 10) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("responses missing", 0, expected_results.size());
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/cau_pkg.sv
rtl/core/cau_req_if.sv
rtl/core/cau_rsp_if.sv
rtl/core/cau_div_pipe.sv
rtl/core/cau_sqrt_pipe.sv
rtl/core/complex_arith_unit_top.sv
dv/complex_arith_unit_top_tb.sv
